// ----- rtl/ptsp_pkg.sv -----
package ptsp_pkg;

    localparam int HP_W = 10;

    localparam int RAMP_LENGTH_DEF = 24;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_PAN       = 3'd1;
    localparam logic [2:0] OP_TILT      = 3'd2;
    localparam logic [2:0] OP_HOME      = 3'd3;
    localparam logic [2:0] OP_ZERO_PAN  = 3'd4;
    localparam logic [2:0] OP_STOP      = 3'd5;
    localparam logic [2:0] OP_MOTOR_ON  = 3'd6;
    localparam logic [2:0] OP_MOTOR_OFF = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SETUP = 2'd1;
    localparam logic [1:0] PH_STEP  = 2'd2;

    localparam logic [2:0] CFG_TILT_MIN   = 3'd0;
    localparam logic [2:0] CFG_TILT_MAX   = 3'd1;
    localparam logic [2:0] CFG_TILT_HOME  = 3'd2;
    localparam logic [2:0] CFG_MAX_STEPS  = 3'd3;
    localparam logic [2:0] CFG_PAN_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_FAST_HALF  = 3'd5;
    localparam logic [2:0] CFG_SLOW_HALF  = 3'd6;
    localparam logic [2:0] CFG_DIR_SETUP  = 3'd7;

    localparam logic [7:0]  RST_TILT_MIN  = 8'd80;
    localparam logic [7:0]  RST_TILT_MAX  = 8'd130;
    localparam logic [7:0]  RST_TILT_HOME = 8'd85;
    localparam logic [9:0]  RST_MAX_STEPS = 10'd70;
    localparam logic [15:0] RST_PAN_LIMIT = 16'd5000;
    localparam logic [9:0]  RST_FAST_HALF = 10'd100;
    localparam logic [9:0]  RST_SLOW_HALF = 10'd450;
    localparam logic [9:0]  RST_DIR_SETUP = 10'd50;

endpackage

// ----- rtl/pan_tilt_stepper_pulse_controller.sv -----
// Pan/tilt stepper pulse controller. Every input transfer is either one
// microsecond tick (opcode 0) or a command, and produces exactly one result
// transfer carrying the step, direction, enable and servo levels, the tilt
// angle, the pan position, a busy flag and a status code. The block takes one
// transfer per clock: the whole state update sits between the input handshake
// and a single output register, and a new transfer is taken while the previous
// result is being read, so a stall on the result side holds the input side
// only while the output register is full. The ramp half-period of the next
// step is prepared ahead of time through a registered multiply by
// (slow - fast), then divided by RAMP_LENGTH through a reciprocal multiply.
// Configuration writes are meant for idle periods only; there is no clearing
// pass after reset.
module pan_tilt_stepper_pulse_controller
    import ptsp_pkg::*;
#(
    parameter int RAMP_LENGTH = RAMP_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [18:3] value, [23:19] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] step_level, [1] dir_level, [2] motor_enabled, [3] servo_attached,
    // [11:4] tilt_angle, [28:12] pan_position, [29] busy_res, [31:30] status
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);

    localparam int EW    = $clog2(RAMP_LENGTH + 1);
    localparam int PW    = HP_W + EW;
    localparam int RL    = $clog2(RAMP_LENGTH);
    localparam int SH    = PW + RL;
    localparam logic [PW:0] RECIP = (PW + 1)'(((64'd1 << SH) / RAMP_LENGTH) + 64'd1);

    logic [7:0]  tilt_min_reg, tilt_max_reg, tilt_home_reg;
    logic [9:0]  max_steps_reg, fast_half_reg, slow_half_reg, dir_setup_reg;
    logic [15:0] pan_limit_reg;

    logic [1:0]         phase_reg, phase_next;
    logic [9:0]         tc_reg, tc_next;
    logic [9:0]         step_index_reg, step_index_next;
    logic [9:0]         step_total_reg, step_total_next;
    logic signed [10:0] move_delta_reg, move_delta_next;
    logic signed [16:0] pan_pos_reg, pan_pos_next;
    logic [7:0]         tilt_reg, tilt_next;
    logic               step_out_reg, step_out_next;
    logic               dir_reg, dir_next;
    logic               enable_reg, enable_next;
    logic               servo_reg, servo_next;
    logic [9:0]         half_reg, half_next;
    logic [1:0]         status_next;

    logic [PW-1:0] prod_reg, prod_next;
    logic          edge_ge_reg, edge_ge_next;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic        in_acc;
    logic [2:0]  op;
    logic signed [15:0] val;
    logic [9:0]  tc_inc;
    logic [9:0]  idx_inc;

    logic [9:0]  ramp_diff;
    logic [9:0]  back_n;
    logic [9:0]  edge_n;
    logic [2*PW:0] ramp_mul;
    logic [9:0]  ramp_q;
    logic [9:0]  half_step;

    logic signed [19:0] val20, lim20, req_c, pos20, pl20, target, steps_a, steps_c;
    logic signed [10:0] steps11;
    logic [9:0]  steps_abs;

    function automatic logic [7:0] tilt_clamp(input logic signed [16:0] v,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
        logic [7:0] r;
        begin
            priority if (v < $signed({9'd0, lo})) begin
                r = lo;
            end else if (v > $signed({9'd0, hi})) begin
                r = hi;
            end else begin
                r = v[7:0];
            end
            return r;
        end
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign op      = s_tdata[2:0];
    assign val     = $signed(s_tdata[18:3]);
    assign tc_inc  = tc_reg + 10'd1;
    assign idx_inc = step_index_reg + 10'd1;

    // Look ahead to the half-period of the next step
    assign ramp_diff = (slow_half_reg > fast_half_reg) ? slow_half_reg - fast_half_reg : 10'd0;
    assign back_n    = (step_total_reg > idx_inc) ? step_total_reg - 10'd1 - idx_inc : 10'd0;
    assign edge_n    = (back_n < idx_inc) ? back_n : idx_inc;
    assign edge_ge_next = edge_n >= HP_W'(RAMP_LENGTH);
    assign prod_next = PW'(ramp_diff * edge_n[EW-1:0]);

    assign ramp_mul  = prod_reg * RECIP;
    assign ramp_q    = ramp_mul[SH+9:SH];
    assign half_step = edge_ge_reg ? fast_half_reg : slow_half_reg - ramp_q;

    // Pan request limiting
    assign val20  = {{4{val[15]}}, val};
    assign lim20  = $signed({10'd0, max_steps_reg});
    assign pos20  = {{3{pan_pos_reg[16]}}, pan_pos_reg};
    assign pl20   = $signed({4'd0, pan_limit_reg});
    assign req_c  = (val20 < -lim20) ? -lim20 : ((val20 > lim20) ? lim20 : val20);
    assign target = pos20 + req_c;

    always_comb begin
        priority if (target > pl20) begin
            steps_a = pl20 - pos20;
        end else if (target < -pl20) begin
            steps_a = -pl20 - pos20;
        end else begin
            steps_a = req_c;
        end
        priority if (steps_a > 20'sd1023) begin
            steps_c = 20'sd1023;
        end else if (steps_a < -20'sd1023) begin
            steps_c = -20'sd1023;
        end else begin
            steps_c = steps_a;
        end
    end

    assign steps11   = steps_c[10:0];
    assign steps_abs = steps11[10] ? 10'(-steps11) : steps11[9:0];

    always_comb begin
        phase_next      = phase_reg;
        tc_next         = tc_reg;
        step_index_next = step_index_reg;
        step_total_next = step_total_reg;
        move_delta_next = move_delta_reg;
        pan_pos_next    = pan_pos_reg;
        tilt_next       = tilt_reg;
        step_out_next   = step_out_reg;
        dir_next        = dir_reg;
        enable_next     = enable_reg;
        servo_next      = servo_reg;
        half_next       = half_reg;
        status_next     = ST_OK;

        if (op == OP_TICK) begin
            unique case (phase_reg)
                PH_SETUP: begin
                    tc_next = tc_inc;
                    if (tc_inc >= dir_setup_reg) begin
                        enable_next   = 1'b1;
                        step_out_next = 1'b1;
                        tc_next       = 10'd0;
                        phase_next    = PH_STEP;
                    end
                end
                PH_STEP: begin
                    tc_next = tc_inc;
                    if (tc_inc >= half_reg) begin
                        tc_next = 10'd0;
                        if (step_out_reg) begin
                            step_out_next = 1'b0;
                        end else begin
                            step_index_next = idx_inc;
                            if (idx_inc >= step_total_reg) begin
                                pan_pos_next = pan_pos_reg + 17'(move_delta_reg);
                                phase_next   = PH_IDLE;
                            end else begin
                                step_out_next = 1'b1;
                                half_next     = half_step;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end else if (phase_reg != PH_IDLE) begin
            status_next = ST_BUSY;
        end else begin
            unique case (op)
                OP_PAN: begin
                    if (steps11 == 11'sd0) begin
                        status_next = ST_ZERO;
                    end else begin
                        dir_next        = !steps11[10];
                        move_delta_next = steps11;
                        step_total_next = steps_abs;
                        step_index_next = 10'd0;
                        tc_next         = 10'd0;
                        half_next       = slow_half_reg;
                        if (dir_setup_reg == 10'd0) begin
                            enable_next   = 1'b1;
                            step_out_next = 1'b1;
                            phase_next    = PH_STEP;
                        end else begin
                            phase_next = PH_SETUP;
                        end
                    end
                end
                OP_TILT: begin
                    tilt_next  = tilt_clamp({val[15], val}, tilt_min_reg, tilt_max_reg);
                    servo_next = 1'b1;
                end
                OP_HOME: begin
                    pan_pos_next = 17'sd0;
                    tilt_next    = tilt_clamp($signed({9'd0, tilt_home_reg}),
                                              tilt_min_reg, tilt_max_reg);
                    servo_next   = 1'b1;
                end
                OP_ZERO_PAN: begin
                    pan_pos_next = 17'sd0;
                end
                OP_STOP: begin
                    enable_next = 1'b0;
                    servo_next  = 1'b0;
                end
                OP_MOTOR_ON: begin
                    enable_next = 1'b1;
                end
                default: begin
                    enable_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_min_reg  <= RST_TILT_MIN;
            tilt_max_reg  <= RST_TILT_MAX;
            tilt_home_reg <= RST_TILT_HOME;
            max_steps_reg <= RST_MAX_STEPS;
            pan_limit_reg <= RST_PAN_LIMIT;
            fast_half_reg <= RST_FAST_HALF;
            slow_half_reg <= RST_SLOW_HALF;
            dir_setup_reg <= RST_DIR_SETUP;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TILT_MIN:  tilt_min_reg  <= cfg_wr_data[7:0];
                CFG_TILT_MAX:  tilt_max_reg  <= cfg_wr_data[7:0];
                CFG_TILT_HOME: tilt_home_reg <= cfg_wr_data[7:0];
                CFG_MAX_STEPS: max_steps_reg <= cfg_wr_data[9:0];
                CFG_PAN_LIMIT: pan_limit_reg <= cfg_wr_data;
                CFG_FAST_HALF: fast_half_reg <= cfg_wr_data[9:0];
                CFG_SLOW_HALF: slow_half_reg <= cfg_wr_data[9:0];
                CFG_DIR_SETUP: dir_setup_reg <= cfg_wr_data[9:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tc_reg         <= 10'd0;
            step_index_reg <= 10'd0;
            step_total_reg <= 10'd0;
            move_delta_reg <= 11'sd0;
            pan_pos_reg    <= 17'sd0;
            tilt_reg       <= RST_TILT_HOME;
            step_out_reg   <= 1'b0;
            dir_reg        <= 1'b0;
            enable_reg     <= 1'b0;
            servo_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (in_acc) begin
                phase_reg      <= phase_next;
                tc_reg         <= tc_next;
                step_index_reg <= step_index_next;
                step_total_reg <= step_total_next;
                move_delta_reg <= move_delta_next;
                pan_pos_reg    <= pan_pos_next;
                tilt_reg       <= tilt_next;
                step_out_reg   <= step_out_next;
                dir_reg        <= dir_next;
                enable_reg     <= enable_next;
                servo_reg      <= servo_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        edge_ge_reg <= edge_ge_next;
        if (in_acc) begin
            half_reg    <= half_next;
            m_tdata_reg <= {status_next,
                            (phase_next != PH_IDLE),
                            pan_pos_next,
                            tilt_next,
                            servo_next,
                            enable_next,
                            dir_next,
                            step_out_next};
        end
    end

    a_step_enabled : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STEP) |-> enable_reg)
        else $error("stepping with the driver disabled");

    a_step_only_moving : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_STEP) |-> !step_out_reg)
        else $error("step output high outside stepping");

    a_index_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STEP) |-> (step_index_reg < step_total_reg))
        else $error("step index beyond step count");

    a_move_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (step_total_reg != 10'd0))
        else $error("move in progress with zero steps");

endmodule
